// ----- sv/ttfl_pkg.sv -----
// Shared types, widths and codes for the tagged TLB with FIFO/LRU replacement.
`default_nettype none

package ttfl_pkg;

  localparam int TLB_ENTRIES_DEF = 16;

  localparam int KIND_W     = 2;
  localparam int PROC_W     = 8;
  localparam int PAGE_W     = 20;
  localparam int FRAME_W    = 16;
  localparam int SLOT_W     = 4;
  localparam int STAMP_W    = 32;
  localparam int COUNT_W    = 32;
  localparam int EIU_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [EIU_W-1:0] EIU_RESET = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY  = 1'b0,
    REG_ENTRIES = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    POLICY_FIFO = 1'b0,
    POLICY_LRU  = 1'b1
  } policy_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic scan;    // step the entry scan
    logic commit;  // write back and load the result register
  } ttfl_cmd_t;

  typedef struct packed {
    logic scan_item;  // incoming transaction needs an entry scan
    logic scan_done;  // last entry compared this cycle
    logic out_free;   // result register can take a new result
  } ttfl_status_t;

endpackage

`default_nettype wire

// ----- sv/ttfl_ctrl.sv -----
// Sequencer for the TLB: accept, scan the entries, write back and hand over the result.
`default_nettype none

module ttfl_ctrl import ttfl_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire ttfl_status_t status,
  output ttfl_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.scan_item ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.scan   = (state == ST_SCAN);
    cmd.commit = (state == ST_FINISH) && status.out_free;
  end

`ifndef SYNTHESIS
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    status.scan_done |-> (state == ST_SCAN))
    else $error("scan completion seen outside the scan state");
`endif

endmodule

`default_nettype wire

// ----- sv/ttfl_dpath.sv -----
// TLB entry store, scan compare/age logic, counters and result register.
`default_nettype none

module ttfl_dpath import ttfl_pkg::*; #(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ttfl_cmd_t          cmd,
  output ttfl_status_t            status,
  input  wire policy_t            replace_policy,
  input  wire logic [EIU_W-1:0]   entries_in_use,
  input  wire logic [KIND_W-1:0]  kind,
  input  wire logic [PROC_W-1:0]  process_number,
  input  wire logic [PAGE_W-1:0]  page_number,
  input  wire logic [FRAME_W-1:0] frame_number,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit,
  output logic [FRAME_W-1:0]      frame_out,
  output logic [SLOT_W-1:0]       slot_used,
  output logic                    replaced_valid,
  output logic [COUNT_W-1:0]      hit_total,
  output logic [COUNT_W-1:0]      miss_total
);

  localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TLB_ENTRIES + 1);
  localparam int KEY_W = PROC_W + PAGE_W;
  localparam int ENT_W = KEY_W + FRAME_W;
  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(TLB_ENTRIES);

  // entry store: key+frame, use stamps, load stamps
  logic [ENT_W-1:0]   entry_mem [TLB_ENTRIES];
  logic [STAMP_W-1:0] use_mem   [TLB_ENTRIES];
  logic [STAMP_W-1:0] load_mem  [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] entry_valid;

  // captured transaction
  kind_t              kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [FRAME_W-1:0] frame_q;
  logic [CNT_W-1:0]   n_q;
  logic [CNT_W-1:0]   n_clamp;

  logic [STAMP_W-1:0] access_clock;
  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] miss_count;
  logic [COUNT_W-1:0] hit_count_next;
  logic [COUNT_W-1:0] miss_count_next;

  // scan pipeline
  logic [CNT_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   rd_addr;
  logic               issue;
  logic               data_vld;
  logic               data_last;
  logic [IDX_W-1:0]   data_idx;
  logic               vld_rd;
  logic [ENT_W-1:0]   ent_rd;
  logic [STAMP_W-1:0] use_rd;
  logic [STAMP_W-1:0] load_rd;

  // scan results
  logic               found;
  logic [IDX_W-1:0]   hit_idx;
  logic [FRAME_W-1:0] hit_frame;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [STAMP_W-1:0] best_age;
  logic [IDX_W-1:0]   best_idx;

  logic               step;
  logic               key_eq;
  logic [STAMP_W-1:0] stamp_sel;
  logic [STAMP_W-1:0] age;
  logic               older;
  logic [IDX_W-1:0]   fill_idx;
  logic               fill_wr;
  logic               use_wr;
  logic [IDX_W-1:0]   use_addr;
  logic               kind_scans;

  always_comb begin
    if (entries_in_use == '0) begin
      n_clamp = CNT_W'(1);
    end else if (32'(entries_in_use) > 32'(TLB_ENTRIES)) begin
      n_clamp = N_MAX;
    end else begin
      n_clamp = CNT_W'(entries_in_use);
    end
  end

  assign kind_scans = (kind_t'(kind) == KIND_LOOKUP) || (kind_t'(kind) == KIND_FILL);

  assign rd_addr = rd_idx[IDX_W-1:0];
  assign issue   = cmd.scan && (rd_idx < n_q);
  assign step    = cmd.scan && data_vld;

  assign key_eq    = vld_rd && (ent_rd[ENT_W-1:FRAME_W] == key_q);
  assign stamp_sel = (replace_policy == POLICY_LRU) ? use_rd : load_rd;
  assign age       = access_clock - stamp_sel;   // modulo 2^32, survives wrap
  assign older     = (data_idx == '0) || (age > best_age);

  assign fill_idx = free_found ? free_idx : best_idx;
  assign fill_wr  = cmd.commit && (kind_q == KIND_FILL);
  assign use_wr   = fill_wr || (cmd.commit && (kind_q == KIND_LOOKUP) && found);
  assign use_addr = fill_wr ? fill_idx : hit_idx;

  assign hit_count_next  = hit_count + COUNT_W'((kind_q == KIND_LOOKUP) && found);
  assign miss_count_next = miss_count + COUNT_W'((kind_q == KIND_LOOKUP) && !found);

  assign status.scan_item = kind_scans;
  assign status.scan_done = data_vld && data_last;
  assign status.out_free  = !out_valid || out_ready;

  // capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind_t'(kind);
      key_q   <= {process_number, page_number};
      frame_q <= frame_number;
      n_q     <= n_clamp;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx       <= '0;
      data_vld     <= 1'b0;
      data_last    <= 1'b0;
      access_clock <= '0;
      hit_count    <= '0;
      miss_count   <= '0;
      entry_valid  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_idx <= '0;
        if (kind_scans) begin
          access_clock <= access_clock + STAMP_W'(1);
        end
      end else if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      data_vld  <= issue;
      data_last <= issue && (rd_idx == n_q - CNT_W'(1));

      if (cmd.commit) begin
        hit_count  <= hit_count_next;
        miss_count <= miss_count_next;
        if (kind_q == KIND_FILL) begin
          entry_valid[fill_idx] <= 1'b1;
        end else if (kind_q == KIND_FLUSH) begin
          entry_valid <= '0;
        end
      end

      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan compare: first match, first free slot, oldest entry
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (step) begin
      if (key_eq && !found) begin
        found     <= 1'b1;
        hit_idx   <= data_idx;
        hit_frame <= ent_rd[FRAME_W-1:0];
      end
      if (!vld_rd && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= data_idx;
      end
      if (older) begin
        best_age <= age;
        best_idx <= data_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      data_idx <= rd_addr;
      vld_rd   <= entry_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fill_wr) begin
      entry_mem[fill_idx] <= {key_q, frame_q};
    end
    if (issue) begin
      ent_rd <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fill_wr) begin
      load_mem[fill_idx] <= access_clock;
    end
    if (issue) begin
      load_rd <= load_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (use_wr) begin
      use_mem[use_addr] <= access_clock;
    end
    if (issue) begin
      use_rd <= use_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_total  <= hit_count_next;
      miss_total <= miss_count_next;
      unique case (kind_q)
        KIND_LOOKUP: begin
          hit            <= found;
          frame_out      <= found ? hit_frame : '0;
          slot_used      <= found ? SLOT_W'(hit_idx) : '0;
          replaced_valid <= 1'b0;
        end
        KIND_FILL: begin
          hit            <= 1'b0;
          frame_out      <= '0;
          slot_used      <= SLOT_W'(fill_idx);
          replaced_valid <= !free_found;
        end
        default: begin
          hit            <= 1'b0;
          frame_out      <= '0;
          slot_used      <= '0;
          replaced_valid <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_fill_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (kind_q == KIND_FILL)) |=> entry_valid[$past(fill_idx)])
    else $error("filled entry not marked valid");

  a_counters_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> ($stable(hit_count) && $stable(miss_count)))
    else $error("hit/miss counters moved without a commit");
`endif

endmodule

`default_nettype wire

// ----- sv/tagged_tlb_fifo_lru_unit.sv -----
// Top level of the tagged TLB: configuration registers, sequencer and datapath.
//
// Fully associative TLB keyed by (process, page). Input transactions arrive on
// in_valid/in_ready with kind, process_number, page_number and frame_number;
// kind selects lookup, fill or flush. Each input transaction gives exactly one
// result transaction on out_valid/out_ready carrying hit, frame, slot, eviction
// flag and the running hit/miss totals.
// Lookup and fill scan the active entries (16 by default) one per cycle
// through the entry store's single registered read port, then write back;
// flush and unknown kinds skip the scan and go straight to write-back.
// One transaction is worked on at a time; the result register lets the next
// transaction be accepted and scanned while the previous result still waits.
// If the receiver stalls, the unit holds in write-back until the result
// register is free; nothing is lost or repeated.
// Reset (rst, synchronous) frees every entry, clears stamp clock and counters
// and sets FIFO policy with all entries in use. No clearing pass is needed.
// Configuration (cfg_write/cfg_index/cfg_data) is to be written by the user
// only while idle; the unit itself does not enforce this.
`default_nettype none

module tagged_tlb_fifo_lru_unit import ttfl_pkg::*; #(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [PROC_W-1:0]     process_number,
  input  wire logic [PAGE_W-1:0]     page_number,
  input  wire logic [FRAME_W-1:0]    frame_number,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       hit,
  output logic [FRAME_W-1:0]         frame_out,
  output logic [SLOT_W-1:0]          slot_used,
  output logic                       replaced_valid,
  output logic [COUNT_W-1:0]         hit_total,
  output logic [COUNT_W-1:0]         miss_total
);

  policy_t           replace_policy;
  logic [EIU_W-1:0]  entries_in_use;
  ttfl_cmd_t         cmd;
  ttfl_status_t      status;

  // configuration registers, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      replace_policy <= POLICY_FIFO;
      entries_in_use <= EIU_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POLICY:  replace_policy <= policy_t'(cfg_data[0]);
        REG_ENTRIES: entries_in_use <= cfg_data[EIU_W-1:0];
        default:     replace_policy <= replace_policy;
      endcase
    end
  end

  // sequencer: idle -> scan (lookup and fill only) -> write-back
  ttfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // entry store, compare/age scan, counters, result register
  ttfl_dpath #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .replace_policy (replace_policy),
    .entries_in_use (entries_in_use),
    .kind           (kind),
    .process_number (process_number),
    .page_number    (page_number),
    .frame_number   (frame_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .frame_out      (frame_out),
    .slot_used      (slot_used),
    .replaced_valid (replaced_valid),
    .hit_total      (hit_total),
    .miss_total     (miss_total)
  );

endmodule

`default_nettype wire
